### design/crcf_pkg.sv
// Shared types, constants and the CRC byte update for the command frame builder.
package crcf_pkg;

  localparam int unsigned MaxPayloadDefault = 100;
  localparam int unsigned BacklogDepth      = 32;
  localparam int unsigned MaxOut            = 8;
  localparam int unsigned BacklogCountW     = $clog2(BacklogDepth);
  localparam int unsigned RoomW             = BacklogCountW + 1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Results made by one item, per kind of item.
  localparam logic [3:0] ResultsHeaderEmpty = 4'd8;
  localparam logic [3:0] ResultsHeaderOne   = 4'd9;
  localparam logic [3:0] ResultsHeaderMore  = 4'd7;
  localparam logic [3:0] ResultsError       = 4'd1;
  localparam logic [3:0] ResultsDataLast    = 4'd3;
  localparam logic [3:0] ResultsDataMiddle  = 4'd1;

  typedef enum logic {
    REG_MAGIC_FIRST  = 1'b0,
    REG_MAGIC_SECOND = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_DATA,
    JOB_ERROR
  } job_kind_t;

  typedef enum logic [3:0] {
    ST_MAGIC_FIRST,
    ST_MAGIC_SECOND,
    ST_CMD,
    ST_SEQ,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_PAYLOAD,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_ERROR
  } step_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        finish;
    logic        has_payload;
    logic [7:0]  cmd;
    logic [7:0]  seq;
    logic [15:0] length;
    logic [7:0]  payload;
    logic [3:0]  keep;
  } job_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/crc16_command_framer_core.sv
// Command frame builder: header, payload, CRC-16/MODBUS trailer, one byte per unstalled cycle.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   item     | item_valid / item_ready    | cmd, seq, payload_length, payload_byte
//   result   | result_valid / result_ready| frame_byte, frame_end, frame_error
//   config   | APB write/read, pready = 1 | magic_first @ 0x0, magic_second @ 0x4
//
// An item is taken in any cycle the two-entry job queue has room; a payload item that
// continues a frame yields one byte, so a frame body streams at one byte a cycle while
// results are taken. The byte sequencer sets the rate: a frame's first item gives the
// header, first payload byte if any and trailer if the frame ends there; a middle item its
// byte; a last item its byte and trailer; an oversized frame an error; swallowed items none.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled result holds in the output register while the sequencer and queue wait;
// item_ready depends only on the registered queue fill, never on result_ready.
module crc16_command_framer_core #(
  parameter int unsigned MAX_PAYLOAD = crcf_pkg::MaxPayloadDefault
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  cmd,
  input  logic [7:0]  seq,
  input  logic [15:0] payload_length,
  input  logic [7:0]  payload_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end,
  output logic        frame_error
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);
  localparam logic [crcf_pkg::BacklogCountW-1:0] BacklogLimit =
    crcf_pkg::BacklogCountW'(crcf_pkg::BacklogDepth - crcf_pkg::MaxOut);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] magic_first;
  logic [7:0] magic_second;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= '0;
      magic_second <= '0;
    end else if (cfg_write) begin
      case (crcf_pkg::reg_index_t'(paddr[2]))
        crcf_pkg::REG_MAGIC_FIRST:  magic_first  <= pwdata[7:0];
        crcf_pkg::REG_MAGIC_SECOND: magic_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (crcf_pkg::reg_index_t'(paddr[2]))
      crcf_pkg::REG_MAGIC_FIRST:  prdata = {24'h000000, magic_first};
      crcf_pkg::REG_MAGIC_SECOND: prdata = {24'h000000, magic_second};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame tracking at item accept: classify the item and build a job for the
  // byte sequencer. backlog_count mirrors how many results a burst-limited
  // consumer would still owe; results that would overflow it are cut from the
  // tail of the job through its keep count.
  // ---------------------------------------------------------------------------
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] frame_length, frame_length_next;
  logic        dropping_frame, dropping_frame_next;
  logic [crcf_pkg::BacklogCountW-1:0] backlog_count, backlog_count_next;

  logic        item_accept;
  logic        job_push;
  crcf_pkg::job_t job_new;
  logic [3:0]  made;
  logic [15:0] pos_inc;
  logic [crcf_pkg::RoomW-1:0] room;
  logic [crcf_pkg::RoomW-1:0] backlog_sum;
  logic [3:0]  kept;

  logic [1:0]  jq_count;

  assign item_ready  = (jq_count != 2'd2);
  assign item_accept = item_valid & item_ready;
  assign pos_inc     = byte_position + 16'd1;

  always_comb begin
    byte_position_next  = byte_position;
    frame_length_next   = frame_length;
    dropping_frame_next = dropping_frame;
    job_push            = 1'b0;
    made                = '0;
    job_new             = '0;
    job_new.kind        = crcf_pkg::JOB_DATA;
    job_new.cmd         = cmd;
    job_new.seq         = seq;
    job_new.length      = payload_length;
    job_new.payload     = payload_byte;

    if (byte_position == 16'd0) begin
      job_push = 1'b1;
      if (payload_length > MaxLen) begin
        // Oversized: one error result, swallow the rest of the frame.
        job_new.kind = crcf_pkg::JOB_ERROR;
        made         = crcf_pkg::ResultsError;
        if (payload_length > 16'd1) begin
          dropping_frame_next = 1'b1;
          frame_length_next   = payload_length;
          byte_position_next  = 16'd1;
        end
      end else begin
        job_new.kind        = crcf_pkg::JOB_HEADER;
        job_new.has_payload = (payload_length != 16'd0);
        job_new.finish      = (payload_length <= 16'd1);
        if (payload_length == 16'd0) begin
          made = crcf_pkg::ResultsHeaderEmpty;
        end else if (payload_length == 16'd1) begin
          made = crcf_pkg::ResultsHeaderOne;
        end else begin
          made               = crcf_pkg::ResultsHeaderMore;
          frame_length_next  = payload_length;
          byte_position_next = 16'd1;
        end
      end
    end else if (dropping_frame) begin
      byte_position_next = pos_inc;
      if (pos_inc >= frame_length) begin
        byte_position_next  = '0;
        frame_length_next   = '0;
        dropping_frame_next = 1'b0;
      end
    end else begin
      job_push            = 1'b1;
      job_new.kind        = crcf_pkg::JOB_DATA;
      job_new.has_payload = 1'b1;
      job_new.finish      = (pos_inc >= frame_length);
      byte_position_next  = pos_inc;
      made                = crcf_pkg::ResultsDataMiddle;
      if (pos_inc >= frame_length) begin
        made               = crcf_pkg::ResultsDataLast;
        byte_position_next = '0;
        frame_length_next  = '0;
      end
    end

    // Cut what no longer fits, then retire one burst worth of results.
    room        = crcf_pkg::RoomW'(crcf_pkg::BacklogDepth) - {1'b0, backlog_count};
    kept        = ({{(crcf_pkg::RoomW-4){1'b0}}, made} < room) ? made : room[3:0];
    job_new.keep = kept;
    backlog_sum = {1'b0, backlog_count} + crcf_pkg::RoomW'(kept);
    if (backlog_sum > crcf_pkg::RoomW'(crcf_pkg::MaxOut)) begin
      backlog_count_next =
        crcf_pkg::BacklogCountW'(backlog_sum - crcf_pkg::RoomW'(crcf_pkg::MaxOut));
    end else begin
      backlog_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      frame_length   <= '0;
      dropping_frame <= 1'b0;
      backlog_count  <= '0;
    end else if (item_accept) begin
      byte_position  <= byte_position_next;
      frame_length   <= frame_length_next;
      dropping_frame <= dropping_frame_next;
      backlog_count  <= backlog_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry job queue between item accept and the byte sequencer
  // ---------------------------------------------------------------------------
  crcf_pkg::job_t jq_mem [2];
  logic           jq_wr;
  logic           jq_rd;
  logic           jq_push;
  logic           jq_pop;
  logic           jq_valid;
  crcf_pkg::job_t head;

  assign jq_push  = item_accept & job_push;
  assign jq_valid = (jq_count != 2'd0);
  assign head     = jq_mem[jq_rd];

  always_ff @(posedge clk) begin
    if (jq_push) begin
      jq_mem[jq_wr] <= job_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jq_wr    <= 1'b0;
      jq_rd    <= 1'b0;
      jq_count <= '0;
    end else begin
      if (jq_push) begin
        jq_wr <= ~jq_wr;
      end
      if (jq_pop) begin
        jq_rd <= ~jq_rd;
      end
      case ({jq_push, jq_pop})
        2'b10:   jq_count <= jq_count + 2'd1;
        2'b01:   jq_count <= jq_count - 2'd1;
        default: jq_count <= jq_count;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sequencer: walk the head job one step a cycle unless the result stalls, fold
  // data bytes into the CRC, and load the result register for steps inside the keep count.
  // ---------------------------------------------------------------------------
  logic            job_first;
  crcf_pkg::step_t step, step_next, cur_step;
  logic [3:0]      emit_idx, cur_idx;
  logic [15:0]     crc, crc_base, crc_next;
  logic            advance;
  logic            step_last;
  logic            step_crc;
  logic            step_emit;
  logic [7:0]      step_byte;
  logic            step_end;
  logic            step_error;

  assign advance = jq_valid & (~result_valid | result_ready);
  assign jq_pop  = advance & step_last;
  assign cur_idx = job_first ? 4'd0 : emit_idx;

  always_comb begin
    cur_step = step;
    if (job_first) begin
      case (head.kind)
        crcf_pkg::JOB_HEADER: cur_step = crcf_pkg::ST_MAGIC_FIRST;
        crcf_pkg::JOB_DATA:   cur_step = crcf_pkg::ST_PAYLOAD;
        crcf_pkg::JOB_ERROR:  cur_step = crcf_pkg::ST_ERROR;
        default:              cur_step = crcf_pkg::ST_ERROR;
      endcase
    end
  end

  always_comb begin
    step_next  = cur_step;
    step_last  = 1'b0;
    step_crc   = 1'b0;
    step_byte  = '0;
    step_end   = 1'b0;
    step_error = 1'b0;
    case (cur_step)
      crcf_pkg::ST_MAGIC_FIRST: begin
        step_byte = magic_first;
        step_next = crcf_pkg::ST_MAGIC_SECOND;
      end
      crcf_pkg::ST_MAGIC_SECOND: begin
        step_byte = magic_second;
        step_next = crcf_pkg::ST_CMD;
      end
      crcf_pkg::ST_CMD: begin
        step_byte = head.cmd;
        step_crc  = 1'b1;
        step_next = crcf_pkg::ST_SEQ;
      end
      crcf_pkg::ST_SEQ: begin
        step_byte = head.seq;
        step_crc  = 1'b1;
        step_next = crcf_pkg::ST_LEN_LO;
      end
      crcf_pkg::ST_LEN_LO: begin
        step_byte = head.length[7:0];
        step_crc  = 1'b1;
        step_next = crcf_pkg::ST_LEN_HI;
      end
      crcf_pkg::ST_LEN_HI: begin
        step_byte = head.length[15:8];
        step_crc  = 1'b1;
        step_next = head.has_payload ? crcf_pkg::ST_PAYLOAD : crcf_pkg::ST_CRC_LO;
      end
      crcf_pkg::ST_PAYLOAD: begin
        step_byte = head.payload;
        step_crc  = 1'b1;
        step_next = crcf_pkg::ST_CRC_LO;
        step_last = ~head.finish;
      end
      crcf_pkg::ST_CRC_LO: begin
        step_byte = crc[7:0];
        step_next = crcf_pkg::ST_CRC_HI;
      end
      crcf_pkg::ST_CRC_HI: begin
        step_byte = crc[15:8];
        step_end  = 1'b1;
        step_last = 1'b1;
      end
      crcf_pkg::ST_ERROR: begin
        step_end   = 1'b1;
        step_error = 1'b1;
        step_last  = 1'b1;
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
  end

  // The command byte opens a fresh CRC.
  assign crc_base  = (cur_step == crcf_pkg::ST_CMD) ? crcf_pkg::CrcInit : crc;
  assign crc_next  = crcf_pkg::crc_update(crc_base, step_byte);
  assign step_emit = (cur_idx < head.keep);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_first <= 1'b1;
      step      <= crcf_pkg::ST_MAGIC_FIRST;
      emit_idx  <= '0;
      crc       <= crcf_pkg::CrcInit;
    end else if (advance) begin
      if (step_crc) begin
        crc <= crc_next;
      end
      if (step_last) begin
        job_first <= 1'b1;
      end else begin
        job_first <= 1'b0;
        step      <= step_next;
        emit_idx  <= cur_idx + 4'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance & step_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance & step_emit) begin
      frame_byte  <= step_byte;
      frame_end   <= step_end;
      frame_error <= step_error;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    jq_count <= 2'd2)
    else $error("job queue overfilled");

  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid & frame_error |-> frame_end)
    else $error("error result without frame end");

  a_drop_in_frame: assert property (@(posedge clk) disable iff (rst)
    dropping_frame |-> (byte_position != 16'd0))
    else $error("dropping outside a frame");

  a_result_from_job: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(jq_count != 2'd0))
    else $error("result loaded with empty job queue");

  a_backlog_bound: assert property (@(posedge clk) disable iff (rst)
    backlog_count <= BacklogLimit)
    else $error("backlog mirror out of range");

endmodule
